FILE: hdl/fat_pkg.sv
`timescale 1ns / 1ps

package fat_pkg;

  localparam int EntryW = 12;
  localparam int CountW = 13;

  localparam logic [EntryW-1:0] ResetMarker = 12'hFFF;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_RANGE  = 2'd1,
    ST_FULL   = 2'd2,
    ST_BROKEN = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    K_READ  = 3'd0,
    K_WRITE = 3'd1,
    K_FIND  = 3'd2,
    K_CHAIN = 3'd3,
    K_COUNT = 3'd4
  } kind_e;

endpackage

FILE: hdl/fat12_allocation_table_engine.sv
`timescale 1ns / 1ps
// Read, write, range error and unknown kind reach S_FINISH straight from idle (read via S_READ);
// find free, free chain and count walk the table in S_SCAN, S_CHAIN or S_COUNT,
// one table entry per cycle through the single table read port.
// Throughput: one item at a time; the next item is taken once the result is registered.
// Reset: after rst_ni releases, a clearing pass writes every entry
// (reserved entries to 0xFFF, the rest to zero) before the first item is taken.
module fat12_allocation_table_engine
  import fat_pkg::*;
#(
  parameter int TABLE_ENTRIES    = 256,
  parameter int RESERVED_ENTRIES = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [EntryW-1:0] cfg_end_marker_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [2:0]        kind_i,
  input  logic [EntryW-1:0] index_i,
  input  logic [EntryW-1:0] value_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        status_o,
  output logic [EntryW-1:0] entry_value_o,
  output logic [CountW-1:0] free_count_o
);

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam logic [AW-1:0]     LastIdx   = AW'(TABLE_ENTRIES - 1);
  localparam logic [CountW-1:0] TableSize = CountW'(TABLE_ENTRIES);
  localparam logic [CountW-1:0] Reserved  = CountW'(RESERVED_ENTRIES);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_SCAN,
    S_CHAIN,
    S_COUNT,
    S_FINISH
  } state_e;

  logic [EntryW-1:0] mem_q [TABLE_ENTRIES];
  logic [EntryW-1:0] rd_q;

  state_e            state_q, state_d;
  logic [AW-1:0]     ptr_q, ptr_d;
  logic [AW-1:0]     cnt_q, cnt_d;
  logic              fwd_q, fwd_d;
  logic [EntryW-1:0] end_marker_q, end_marker_d;
  status_e           res_status_q, res_status_d;
  logic [EntryW-1:0] res_entry_q, res_entry_d;
  logic [CountW-1:0] res_count_q, res_count_d;
  logic              out_valid_q, out_valid_d;
  status_e           status_q, status_d;
  logic [EntryW-1:0] entry_q, entry_d;
  logic [CountW-1:0] count_q, count_d;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [EntryW-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;

  always_comb begin
    logic              in_range;
    logic [EntryW-1:0] link;
    logic [AW-1:0]     nxt;

    in_range     = {1'b0, index_i} < TableSize;
    link         = fwd_q ? '0 : rd_q;
    nxt          = (ptr_q == LastIdx) ? '0 : ptr_q + AW'(1);

    state_d      = state_q;
    ptr_d        = ptr_q;
    cnt_d        = cnt_q;
    fwd_d        = 1'b0;
    end_marker_d = cfg_valid_i ? cfg_end_marker_i : end_marker_q;
    res_status_d = res_status_q;
    res_entry_d  = res_entry_q;
    res_count_d  = res_count_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    status_d     = status_q;
    entry_d      = entry_q;
    count_d      = count_q;
    mem_we       = 1'b0;
    mem_waddr    = ptr_q;
    mem_wdata    = '0;
    mem_re       = 1'b0;
    mem_raddr    = ptr_q;

    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = (CountW'(ptr_q) < Reserved) ? ResetMarker : '0;
        ptr_d     = nxt;
        if (ptr_q == LastIdx) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          res_status_d = ST_OK;
          res_entry_d  = '0;
          res_count_d  = '0;
          cnt_d        = '0;
          ptr_d        = index_i[AW-1:0];
          mem_raddr    = index_i[AW-1:0];
          state_d      = S_FINISH;
          case (kind_e'(kind_i))
            K_READ: begin
              if (in_range) begin
                mem_re  = 1'b1;
                state_d = S_READ;
              end else begin
                res_status_d = ST_RANGE;
              end
            end
            K_WRITE: begin
              if (in_range) begin
                mem_we    = 1'b1;
                mem_waddr = index_i[AW-1:0];
                mem_wdata = value_i;
              end else begin
                res_status_d = ST_RANGE;
              end
            end
            K_FIND: begin
              if (in_range) begin
                mem_re  = 1'b1;
                state_d = S_SCAN;
              end else begin
                res_status_d = ST_RANGE;
              end
            end
            K_CHAIN: begin
              if (in_range) begin
                mem_re  = 1'b1;
                state_d = S_CHAIN;
              end else begin
                res_status_d = ST_RANGE;
              end
            end
            K_COUNT: begin
              ptr_d     = '0;
              mem_raddr = '0;
              mem_re    = 1'b1;
              state_d   = S_COUNT;
            end
            default: begin
              state_d = S_FINISH;
            end
          endcase
        end
      end
      S_READ: begin
        res_entry_d = rd_q;
        state_d     = S_FINISH;
      end
      S_SCAN: begin
        if (rd_q == '0) begin
          res_entry_d = EntryW'(ptr_q);
          state_d     = S_FINISH;
        end else if (cnt_q == LastIdx) begin
          res_status_d = ST_FULL;
          state_d      = S_FINISH;
        end else begin
          cnt_d     = cnt_q + AW'(1);
          ptr_d     = nxt;
          mem_raddr = nxt;
          mem_re    = 1'b1;
        end
      end
      S_CHAIN: begin
        mem_we = 1'b1;
        if (link == end_marker_q) begin
          state_d = S_FINISH;
        end else if ({1'b0, link} >= TableSize || cnt_q == LastIdx) begin
          res_status_d = ST_BROKEN;
          state_d      = S_FINISH;
        end else begin
          cnt_d     = cnt_q + AW'(1);
          ptr_d     = link[AW-1:0];
          mem_raddr = link[AW-1:0];
          mem_re    = 1'b1;
          // the entry cleared now is not yet visible to this read
          fwd_d     = (link[AW-1:0] == ptr_q);
        end
      end
      S_COUNT: begin
        if (rd_q == '0) begin
          res_count_d = res_count_q + CountW'(1);
        end
        if (ptr_q == LastIdx) begin
          state_d = S_FINISH;
        end else begin
          ptr_d     = nxt;
          mem_raddr = nxt;
          mem_re    = 1'b1;
        end
      end
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          status_d    = res_status_q;
          entry_d     = res_entry_q;
          count_d     = res_count_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      ptr_q        <= '0;
      cnt_q        <= '0;
      fwd_q        <= 1'b0;
      end_marker_q <= ResetMarker;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      ptr_q        <= ptr_d;
      cnt_q        <= cnt_d;
      fwd_q        <= fwd_d;
      end_marker_q <= end_marker_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_status_q <= res_status_d;
    res_entry_q  <= res_entry_d;
    res_count_q  <= res_count_d;
    status_q     <= status_d;
    entry_q      <= entry_d;
    count_q      <= count_d;
  end

  assign cfg_ready_o   = 1'b1;
  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign entry_value_o = entry_q;
  assign free_count_o  = count_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("item taken while previous item still in progress");

  a_walk_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN || state_q == S_COUNT) |-> CountW'(ptr_q) < TableSize)
    else $error("scan pointer beyond table");

  a_finish_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FINISH && out_valid_q && !out_ready_i |=> state_q == S_FINISH)
    else $error("result dropped while output stalled");

  a_count_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && free_count_o != '0 |-> status_o == ST_OK)
    else $error("free count with error status");

  a_entry_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && entry_value_o != '0 |-> status_o == ST_OK)
    else $error("entry value with error status");

endmodule
